### src/line_token_scanner_defines.svh
// assertion macros for the line token scanner checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef LINE_TOKEN_SCANNER_DEFINES_SVH
`define LINE_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line_token_scanner: same-cycle check failed");

// next-cycle implication, disabled during reset
`define LTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line_token_scanner: next-cycle check failed");

`endif

### src/lts_pkg.sv
// shared types and constants of the line token scanner
// result field widths, token kinds, error codes, result queue sizing; no dependencies
`default_nettype none

package lts_pkg;

    parameter int LINE_MAX_DEF = 1024;

    parameter int KIND_W  = 5;
    parameter int ERR_W   = 3;
    parameter int START_W = 10;
    parameter int LEN_W   = 11;

    // results one input byte can cause, and the result queue behind the scanner
    parameter int MAX_RES   = 3;
    parameter int RES_CNT_W = $clog2(MAX_RES + 1);
    parameter int RES_DEPTH = 8;

    // token kinds
    parameter logic [KIND_W-1:0] K_STR    = 5'd0;
    parameter logic [KIND_W-1:0] K_CHR    = 5'd1;
    parameter logic [KIND_W-1:0] K_NUM    = 5'd2;
    parameter logic [KIND_W-1:0] K_NAME   = 5'd3;
    parameter logic [KIND_W-1:0] K_LPAREN = 5'd4;
    parameter logic [KIND_W-1:0] K_RPAREN = 5'd5;
    parameter logic [KIND_W-1:0] K_LBRACE = 5'd6;
    parameter logic [KIND_W-1:0] K_RBRACE = 5'd7;
    parameter logic [KIND_W-1:0] K_COMMA  = 5'd8;
    parameter logic [KIND_W-1:0] K_COLON  = 5'd9;
    parameter logic [KIND_W-1:0] K_EQUAL  = 5'd10;
    parameter logic [KIND_W-1:0] K_THEN   = 5'd11;
    parameter logic [KIND_W-1:0] K_REPEAT = 5'd12;
    parameter logic [KIND_W-1:0] K_PLUS   = 5'd13;
    parameter logic [KIND_W-1:0] K_MINUS  = 5'd14;
    parameter logic [KIND_W-1:0] K_STAR   = 5'd15;
    parameter logic [KIND_W-1:0] K_LT     = 5'd16;
    parameter logic [KIND_W-1:0] K_GE     = 5'd17;
    parameter logic [KIND_W-1:0] K_NE     = 5'd18;
    parameter logic [KIND_W-1:0] K_AND    = 5'd19;
    parameter logic [KIND_W-1:0] K_OR     = 5'd20;
    parameter logic [KIND_W-1:0] K_EQEQ   = 5'd21;
    parameter logic [KIND_W-1:0] K_SEMI   = 5'd22;

    // error codes
    parameter logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    parameter logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd1;
    parameter logic [ERR_W-1:0] ERR_OPEN_STR  = 3'd2;
    parameter logic [ERR_W-1:0] ERR_OPEN_CHR  = 3'd3;
    parameter logic [ERR_W-1:0] ERR_LINE_LONG = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ERR_W-1:0]   err;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_result;

    // results of one byte, in order, count 0 when nothing is pushed
    typedef struct packed {
        logic [RES_CNT_W-1:0]       count;
        t_result [MAX_RES-1:0]      res;
    } t_batch;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_entry;

endpackage

`default_nettype wire

### src/lts_scan.sv
// scanner core: input register, scan state and the per-byte step logic
// depends on lts_pkg; hands a batch of up to three results to the result queue
`default_nettype none

module lts_scan #(
    parameter int LINE_MAX = lts_pkg::LINE_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_ch,
    input  logic            i_line_end,
    input  logic            i_room,
    output lts_pkg::t_batch o_batch
);

    localparam int POS_W = $clog2(LINE_MAX + 1);
    localparam int BEG_W = $clog2(LINE_MAX);
    localparam int AW    = (POS_W > lts_pkg::LEN_W) ? POS_W : lts_pkg::LEN_W;
    localparam int CW    = lts_pkg::RES_CNT_W;

    typedef enum logic [6:0] {
        M_IDLE = 7'b0000001,
        M_OP   = 7'b0000010,
        M_KW   = 7'b0000100,
        M_NAME = 7'b0001000,
        M_NUM  = 7'b0010000,
        M_STR  = 7'b0100000,
        M_CHR  = 7'b1000000
    } t_mode;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_name_ch(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_num_ch(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == ".") || (c == "-");
    endfunction

    // one-byte punctuators, K_STR where the byte is none of them
    function automatic logic [lts_pkg::KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [lts_pkg::KIND_W-1:0] k;
        case (c)
            "(": k = lts_pkg::K_LPAREN;
            ")": k = lts_pkg::K_RPAREN;
            "{": k = lts_pkg::K_LBRACE;
            "}": k = lts_pkg::K_RBRACE;
            ",": k = lts_pkg::K_COMMA;
            ":": k = lts_pkg::K_COLON;
            "+": k = lts_pkg::K_PLUS;
            "*": k = lts_pkg::K_STAR;
            ";": k = lts_pkg::K_SEMI;
            default: k = lts_pkg::K_STR;
        endcase
        return k;
    endfunction

    // expected keyword byte, choice low for repeat and high for then
    function automatic logic [7:0] kw_byte(input logic choice, input logic [2:0] prog);
        logic [7:0] b;
        case ({choice, prog})
            4'b0_001: b = "e";
            4'b0_010: b = "p";
            4'b0_011: b = "e";
            4'b0_100: b = "a";
            4'b0_101: b = "t";
            4'b1_001: b = "h";
            4'b1_010: b = "e";
            4'b1_011: b = "n";
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic lts_pkg::t_result mk(
        input logic [lts_pkg::KIND_W-1:0] kind,
        input logic [lts_pkg::ERR_W-1:0]  err,
        input logic [AW-1:0]              start,
        input logic [AW-1:0]              len
    );
        lts_pkg::t_result r;
        r.kind  = kind;
        r.err   = err;
        r.start = start[lts_pkg::START_W-1:0];
        r.len   = len[lts_pkg::LEN_W-1:0];
        return r;
    endfunction

    // input register
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_end;
    logic       w_fire;

    // scan state
    t_mode             r_mode,      n_mode;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [BEG_W-1:0]  r_begin,     n_begin;
    logic [2:0]        r_kw_prog,   n_kw_prog;
    logic              r_kw_choice, n_kw_choice;
    logic [7:0]        r_op_byte,   n_op_byte;
    logic              r_op_two,    n_op_two;
    logic              r_dropped,   n_dropped;

    // step working signals
    logic [CW-1:0]                   w_cnt;
    lts_pkg::t_result [lts_pkg::MAX_RES-1:0] w_res;
    logic                            w_clr;
    logic                            w_do_op;
    logic                            w_op_end;
    logic                            w_gen;
    logic                            w_fresh;
    logic [7:0]                      w_pp;
    logic [AW-1:0]                   w_bb;
    logic [AW-1:0]                   w_pos_x;
    logic [AW-1:0]                   w_beg_x;
    logic [7:0]                      w_second;
    logic [lts_pkg::KIND_W-1:0]      w_kind2;
    logic [lts_pkg::KIND_W-1:0]      w_kind1;
    logic [lts_pkg::KIND_W-1:0]      w_sk;
    logic [2:0]                      w_kw_len;
    logic [2:0]                      w_kw_next;

    assign o_in_ready = !r_in_valid || i_room;
    assign w_fire     = r_in_valid && i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch  <= i_ch;
            r_end <= i_line_end;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_begin     = r_begin;
        n_kw_prog   = r_kw_prog;
        n_kw_choice = r_kw_choice;
        n_op_byte   = r_op_byte;
        n_op_two    = r_op_two;
        n_dropped   = r_dropped;

        w_cnt     = '0;
        w_res     = '0;
        w_clr     = 1'b0;
        w_do_op   = 1'b0;
        w_op_end  = 1'b0;
        w_gen     = 1'b0;
        w_fresh   = 1'b0;
        w_pp      = r_op_byte;
        w_pos_x   = AW'(r_pos);
        w_beg_x   = AW'(r_begin);
        w_bb      = w_beg_x;
        w_second  = "|";
        w_kind2   = lts_pkg::K_OR;
        w_kind1   = lts_pkg::K_STR;
        w_sk      = single_kind(r_ch);
        w_kw_len  = r_kw_choice ? 3'd4 : 3'd6;
        w_kw_next = r_kw_prog + 3'd1;

        if (w_fire) begin
            if (r_end) begin
                if (!r_dropped) begin
                    case (r_mode)
                        M_OP: begin
                            w_do_op  = 1'b1;
                            w_op_end = 1'b1;
                        end
                        M_KW: begin
                            w_res[w_cnt] = mk(lts_pkg::K_NAME, lts_pkg::ERR_NONE,
                                              w_beg_x, AW'(r_kw_prog));
                            w_cnt = w_cnt + CW'(1);
                        end
                        M_NAME: begin
                            w_res[w_cnt] = mk(lts_pkg::K_NAME, lts_pkg::ERR_NONE,
                                              w_beg_x, w_pos_x - w_beg_x);
                            w_cnt = w_cnt + CW'(1);
                        end
                        M_NUM: begin
                            w_res[w_cnt] = mk(lts_pkg::K_NUM, lts_pkg::ERR_NONE,
                                              w_beg_x, w_pos_x - w_beg_x);
                            w_cnt = w_cnt + CW'(1);
                        end
                        M_STR: begin
                            w_res[w_cnt] = mk(lts_pkg::K_STR, lts_pkg::ERR_OPEN_STR,
                                              w_beg_x, '0);
                            w_cnt = w_cnt + CW'(1);
                        end
                        M_CHR: begin
                            w_res[w_cnt] = mk(lts_pkg::K_STR, lts_pkg::ERR_OPEN_CHR,
                                              w_beg_x, '0);
                            w_cnt = w_cnt + CW'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (!r_dropped) begin
                if (r_pos >= POS_W'(LINE_MAX)) begin
                    w_res[w_cnt] = mk(lts_pkg::K_STR, lts_pkg::ERR_LINE_LONG, '0, '0);
                    w_cnt = w_cnt + CW'(1);
                    w_clr     = 1'b1;
                    n_dropped = 1'b1;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                    case (r_mode)
                        M_OP: begin
                            w_clr   = 1'b1;
                            w_do_op = 1'b1;
                        end
                        M_KW: begin
                            if (r_ch == kw_byte(r_kw_choice, r_kw_prog)) begin
                                n_kw_prog = w_kw_next;
                                if (w_kw_next == w_kw_len) begin
                                    w_res[w_cnt] = mk(r_kw_choice ? lts_pkg::K_THEN
                                                                  : lts_pkg::K_REPEAT,
                                                      lts_pkg::ERR_NONE, w_beg_x,
                                                      AW'(w_kw_len));
                                    w_cnt = w_cnt + CW'(1);
                                    w_clr = 1'b1;
                                end
                            end else if (is_name_ch(r_ch)) begin
                                n_mode    = M_NAME;
                                n_kw_prog = '0;
                            end else begin
                                w_res[w_cnt] = mk(lts_pkg::K_NAME, lts_pkg::ERR_NONE,
                                                  w_beg_x, AW'(r_kw_prog));
                                w_cnt = w_cnt + CW'(1);
                                w_clr   = 1'b1;
                                w_fresh = 1'b1;
                            end
                        end
                        M_NAME, M_NUM: begin
                            if ((r_mode == M_NAME) ? !is_name_ch(r_ch) : !is_num_ch(r_ch)) begin
                                w_res[w_cnt] = mk((r_mode == M_NAME) ? lts_pkg::K_NAME
                                                                     : lts_pkg::K_NUM,
                                                  lts_pkg::ERR_NONE, w_beg_x,
                                                  w_pos_x - w_beg_x);
                                w_cnt = w_cnt + CW'(1);
                                w_clr   = 1'b1;
                                w_fresh = 1'b1;
                            end
                        end
                        M_STR, M_CHR: begin
                            if (r_ch == ((r_mode == M_STR) ? 8'h22 : 8'h27)) begin
                                w_res[w_cnt] = mk((r_mode == M_STR) ? lts_pkg::K_STR
                                                                    : lts_pkg::K_CHR,
                                                  lts_pkg::ERR_NONE, w_beg_x + AW'(1),
                                                  w_pos_x - w_beg_x - AW'(1));
                                w_cnt = w_cnt + CW'(1);
                                w_clr = 1'b1;
                            end
                        end
                        default: begin
                            w_clr   = 1'b1;
                            w_fresh = 1'b1;
                        end
                    endcase
                end
            end

            if (w_clr) begin
                n_mode      = M_IDLE;
                n_kw_prog   = '0;
                n_kw_choice = 1'b0;
                n_op_byte   = '0;
                n_op_two    = 1'b0;
            end

            // resolve a held operator against this byte or the line end
            if (w_do_op) begin
                if (r_op_two) begin
                    if (!w_op_end && (r_ch == ">")) begin
                        w_res[w_cnt] = mk(lts_pkg::K_REPEAT, lts_pkg::ERR_NONE, w_bb, AW'(3));
                        w_cnt = w_cnt + CW'(1);
                    end else begin
                        w_res[w_cnt] = mk(lts_pkg::K_LT, lts_pkg::ERR_NONE, w_bb, AW'(1));
                        w_cnt = w_cnt + CW'(1);
                        w_pp  = "-";
                        w_bb  = w_bb + AW'(1);
                        w_gen = 1'b1;
                    end
                end else if (w_pp == "<") begin
                    if (!w_op_end && (r_ch == "-")) begin
                        n_mode    = M_OP;
                        n_op_byte = "<";
                        n_op_two  = 1'b1;
                    end else begin
                        w_res[w_cnt] = mk(lts_pkg::K_LT, lts_pkg::ERR_NONE, w_bb, AW'(1));
                        w_cnt = w_cnt + CW'(1);
                        w_fresh = !w_op_end;
                    end
                end else begin
                    w_gen = 1'b1;
                end

                if (w_gen) begin
                    case (w_pp)
                        "-": begin
                            w_second = ">";
                            w_kind2  = lts_pkg::K_THEN;
                            w_kind1  = lts_pkg::K_MINUS;
                        end
                        "=": begin
                            w_second = "=";
                            w_kind2  = lts_pkg::K_EQEQ;
                            w_kind1  = lts_pkg::K_EQUAL;
                        end
                        "&": begin
                            w_second = "&";
                            w_kind2  = lts_pkg::K_AND;
                        end
                        ">": begin
                            w_second = "=";
                            w_kind2  = lts_pkg::K_GE;
                        end
                        "!": begin
                            w_second = "=";
                            w_kind2  = lts_pkg::K_NE;
                        end
                        default: begin
                            w_second = "|";
                            w_kind2  = lts_pkg::K_OR;
                        end
                    endcase
                    if (!w_op_end && (r_ch == w_second)) begin
                        w_res[w_cnt] = mk(w_kind2, lts_pkg::ERR_NONE, w_bb, AW'(2));
                        w_cnt = w_cnt + CW'(1);
                    end else if (w_kind1 == lts_pkg::K_STR) begin
                        // lone first byte of a two-byte operator
                        w_res[w_cnt] = mk(lts_pkg::K_STR, lts_pkg::ERR_UNKNOWN, w_bb, '0);
                        w_cnt = w_cnt + CW'(1);
                        n_dropped = 1'b1;
                    end else begin
                        w_res[w_cnt] = mk(w_kind1, lts_pkg::ERR_NONE, w_bb, AW'(1));
                        w_cnt = w_cnt + CW'(1);
                        w_fresh = !w_op_end;
                    end
                end
            end

            // this byte starts a new token
            if (w_fresh && !is_space(r_ch)) begin
                if (w_sk != lts_pkg::K_STR) begin
                    w_res[w_cnt] = mk(w_sk, lts_pkg::ERR_NONE, w_pos_x, AW'(1));
                    w_cnt = w_cnt + CW'(1);
                end else begin
                    n_begin = r_pos[BEG_W-1:0];
                    case (r_ch)
                        "<", "-", "=", "&", ">", "!", "|": begin
                            n_mode    = M_OP;
                            n_op_byte = r_ch;
                            n_op_two  = 1'b0;
                        end
                        8'h22: n_mode = M_STR;
                        8'h27: n_mode = M_CHR;
                        "r", "t": begin
                            n_mode      = M_KW;
                            n_kw_choice = (r_ch == "t");
                            n_kw_prog   = 3'd1;
                        end
                        default: begin
                            if (is_alpha(r_ch)) begin
                                n_mode = M_NAME;
                            end else if (is_digit(r_ch)) begin
                                n_mode = M_NUM;
                            end else begin
                                w_res[w_cnt] = mk(lts_pkg::K_STR, lts_pkg::ERR_UNKNOWN,
                                                  w_pos_x, '0);
                                w_cnt = w_cnt + CW'(1);
                                n_dropped = 1'b1;
                            end
                        end
                    endcase
                end
            end

            if (r_end) begin
                n_mode      = M_IDLE;
                n_kw_prog   = '0;
                n_kw_choice = 1'b0;
                n_op_byte   = '0;
                n_op_two    = 1'b0;
                n_pos       = '0;
                n_begin     = '0;
                n_dropped   = 1'b0;
            end
        end
    end

    assign o_batch.count = w_cnt;
    assign o_batch.res   = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_pos       <= '0;
            r_begin     <= '0;
            r_kw_prog   <= '0;
            r_kw_choice <= 1'b0;
            r_op_byte   <= '0;
            r_op_two    <= 1'b0;
            r_dropped   <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_begin     <= n_begin;
            r_kw_prog   <= n_kw_prog;
            r_kw_choice <= n_kw_choice;
            r_op_byte   <= n_op_byte;
            r_op_two    <= n_op_two;
            r_dropped   <= n_dropped;
        end
    end

endmodule

`default_nettype wire

### src/lts_res_queue.sv
// result queue: takes up to three results a cycle, hands out one a cycle while i_ready is high
// depends on lts_pkg; marks the last result of each batch
`default_nettype none

module lts_res_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lts_pkg::t_batch i_batch,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output lts_pkg::t_entry o_entry
);

    localparam int PTR_W = $clog2(lts_pkg::RES_DEPTH);
    localparam int CNT_W = $clog2(lts_pkg::RES_DEPTH + 1);

    lts_pkg::t_entry    r_mem [lts_pkg::RES_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               w_pop;

    // room for a full batch
    assign o_room  = r_count <= CNT_W'(lts_pkg::RES_DEPTH - lts_pkg::MAX_RES);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    assign n_wr_ptr = r_wr_ptr + PTR_W'(i_batch.count);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(w_pop);
    assign n_count  = r_count + CNT_W'(i_batch.count) - CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < lts_pkg::MAX_RES; k++) begin
            if (k < int'(i_batch.count)) begin
                r_mem[r_wr_ptr + PTR_W'(k)] <= '{res:  i_batch.res[k],
                                                 last: (k == int'(i_batch.count) - 1)};
            end
        end
    end

endmodule

`default_nettype wire

### src/line_token_scanner.sv
// top level of the line token scanner
// depends on lts_pkg, lts_scan and lts_res_queue
`default_nettype none

// Feed one line a byte per transaction and close it with a line_end transaction; tokens
// come out as kind, start offset and length, quotes excluded, with last_of_run set on the
// final result caused by an input. A byte enters the input register and is scanned once
// the result queue has room, pushing its zero to three results into an eight-entry result
// queue, so the first result is valid in the cycle after its byte is scanned. The block
// takes one byte per cycle as long as the queue has three free entries; results leave at
// one per cycle while out_ready is high, so input that yields more than one result per
// byte is paced by the output side. Errors come out as results with the string kind and
// zero length, after which the rest of the line yields nothing until line_end. The first
// byte at offset LINE_MAX gives a line-too-long error.
module line_token_scanner #(
    parameter int LINE_MAX = lts_pkg::LINE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_ch,
    input  logic                          i_line_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lts_pkg::KIND_W-1:0]    o_token_kind,
    output logic [lts_pkg::ERR_W-1:0]     o_error_code,
    output logic [lts_pkg::START_W-1:0]   o_token_start,
    output logic [lts_pkg::LEN_W-1:0]     o_token_length,
    output logic                          o_last_of_run
);

    lts_pkg::t_batch w_batch;
    lts_pkg::t_entry w_entry;
    logic            w_room;

    lts_scan #(
        .LINE_MAX (LINE_MAX)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_ch       (i_ch),
        .i_line_end (i_line_end),
        .i_room     (w_room),
        .o_batch    (w_batch)
    );

    lts_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_batch (w_batch),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_entry (w_entry)
    );

    assign o_token_kind   = w_entry.res.kind;
    assign o_error_code   = w_entry.res.err;
    assign o_token_start  = w_entry.res.start;
    assign o_token_length = w_entry.res.len;
    assign o_last_of_run  = w_entry.last;

endmodule

`default_nettype wire

### src/lts_checker.sv
// port-level checks for the line token scanner, bound to the top level
// depends on lts_pkg and line_token_scanner_defines.svh
`default_nettype none

`include "line_token_scanner_defines.svh"

module lts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lts_pkg::KIND_W-1:0]    i_token_kind,
    input logic [lts_pkg::ERR_W-1:0]     i_error_code,
    input logic [lts_pkg::START_W-1:0]   i_token_start,
    input logic [lts_pkg::LEN_W-1:0]     i_token_length,
    input logic                          i_last_of_run
);

    // a stalled result transaction keeps its payload
    `LTS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_token_kind) && $stable(i_error_code) && $stable(i_token_start) && $stable(i_token_length) && $stable(i_last_of_run))

    // an error drops the line, so it is always the final result of its byte
    `LTS_ASSERT_IMPL(a_err_shape, i_out_valid && (i_error_code != lts_pkg::ERR_NONE), i_last_of_run && (i_token_kind == lts_pkg::K_STR) && (i_token_length == '0) && (i_error_code <= lts_pkg::ERR_LINE_LONG))

    `LTS_ASSERT_IMPL(a_long_at_zero, i_out_valid && (i_error_code == lts_pkg::ERR_LINE_LONG), i_token_start == '0)

    // keywords and their arrow spellings have fixed lengths
    `LTS_ASSERT_IMPL(a_kw_len, i_out_valid && (i_error_code == lts_pkg::ERR_NONE) && ((i_token_kind == lts_pkg::K_THEN) || (i_token_kind == lts_pkg::K_REPEAT)), (i_token_kind == lts_pkg::K_THEN) ? ((i_token_length == 11'd2) || (i_token_length == 11'd4)) : ((i_token_length == 11'd3) || (i_token_length == 11'd6)))

endmodule

bind line_token_scanner lts_checker u_lts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_token_kind   (o_token_kind),
    .i_error_code   (o_error_code),
    .i_token_start  (o_token_start),
    .i_token_length (o_token_length),
    .i_last_of_run  (o_last_of_run)
);

`default_nettype wire
